FILE: design/arp_cache_and_responder_assert.svh
// Assertion macros shared by the ARP cache checker.
`ifndef ARP_CACHE_AND_RESPONDER_ASSERT_SVH
`define ARP_CACHE_AND_RESPONDER_ASSERT_SVH

// Checked only outside reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/arpc_pkg.sv
// Types and constants shared by the ARP cache and responder.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

  localparam logic [1:0]  FUNC_RX      = 2'd0;
  localparam logic [1:0]  FUNC_LOOKUP  = 2'd1;
  localparam logic [1:0]  FUNC_REQUEST = 2'd2;

  localparam logic [0:0]  REG_OWN_IP   = 1'b0;
  localparam logic [0:0]  REG_OWN_MAC  = 1'b1;

  localparam logic [15:0] MIN_ARP_LEN  = 16'd28;
  localparam logic [15:0] HTYPE_ETHER  = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
  localparam logic [15:0] OP_IN_REQ    = 16'd1;

  localparam logic [1:0]  OP_REQUEST   = 2'd1;
  localparam logic [1:0]  OP_REPLY     = 2'd2;

  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One unit of work for the back end.
  typedef struct packed {
    logic        learn;    // learn key_ip -> mac
    logic        lookup;   // answer a lookup of key_ip
    logic        frame;    // emit an ARP frame
    logic [31:0] key_ip;
    logic [47:0] mac;      // learned MAC, also frame destination
    logic [1:0]  opcode;
    logic [31:0] tgt_ip;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

FILE: design/arpc_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module arpc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  arpc_pkg::cmd_t     push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               nonempty,
  output arpc_pkg::cmd_t     head
);

  arpc_pkg::cmd_t                     slots [arpc_pkg::QUEUE_DEPTH];
  logic [arpc_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [arpc_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [arpc_pkg::QUEUE_CNT_W-1:0]   count;
  logic                               do_push;
  logic                               do_pop;

  assign full     = (count == arpc_pkg::QUEUE_CNT_W'(arpc_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == arpc_pkg::QUEUE_PTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == arpc_pkg::QUEUE_PTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/arpc_front.sv
// Front end: accepts input items and turns them into back-end commands.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front (
  input  wire logic          in_valid,
  input  wire logic [1:0]    func,
  input  wire logic [15:0]   rx_len,
  input  wire logic [15:0]   hw_type,
  input  wire logic [15:0]   proto_type,
  input  wire logic [15:0]   arp_opcode_in,
  input  wire logic [47:0]   sender_mac_in,
  input  wire logic [31:0]   sender_ip_in,
  input  wire logic [31:0]   query_ip,
  input  wire logic [31:0]   own_ip,
  input  wire logic          q_full,
  output logic               in_stall,
  output logic               push,
  output arpc_pkg::cmd_t     cmd
);

  logic pkt_ok;
  logic has_work;

  assign in_stall = q_full;
  assign pkt_ok   = (rx_len >= arpc_pkg::MIN_ARP_LEN) &&
                    (hw_type == arpc_pkg::HTYPE_ETHER) &&
                    (proto_type == arpc_pkg::PTYPE_IPV4);

  always_comb begin
    cmd        = '0;
    cmd.key_ip = query_ip;
    cmd.tgt_ip = query_ip;
    case (func)
      arpc_pkg::FUNC_RX: begin
        cmd.learn  = pkt_ok && (sender_ip_in != '0) && (sender_ip_in != own_ip);
        cmd.frame  = pkt_ok && (arp_opcode_in == arpc_pkg::OP_IN_REQ) &&
                     (query_ip == own_ip);
        cmd.key_ip = sender_ip_in;
        cmd.mac    = sender_mac_in;
        cmd.opcode = arpc_pkg::OP_REPLY;
        cmd.tgt_ip = sender_ip_in;
      end
      arpc_pkg::FUNC_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      arpc_pkg::FUNC_REQUEST: begin
        cmd.frame  = 1'b1;
        cmd.mac    = arpc_pkg::MAC_BROADCAST;
        cmd.opcode = arpc_pkg::OP_REQUEST;
      end
      default: begin
        // unknown function: drop
      end
    endcase
  end

  // Items with nothing to do are taken and dropped here.
  assign has_work = cmd.learn || cmd.lookup || cmd.frame;
  assign push     = in_valid && !q_full && has_work;

endmodule
`default_nettype wire

FILE: design/arpc_back.sv
// Back end: cache memory, sequential match, learning and the result register.
`timescale 1ns / 1ps
`default_nettype none
module arpc_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nonempty,
  input  arpc_pkg::cmd_t     q_head,
  output logic               q_pop,
  input  wire logic [31:0]   own_ip,
  input  wire logic [47:0]   own_mac,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               result_kind,
  output logic               hit,
  output logic [47:0]        found_mac,
  output logic [47:0]        eth_dest_mac,
  output logic [1:0]         arp_opcode_out,
  output logic [47:0]        pkt_sender_mac,
  output logic [31:0]        pkt_sender_ip,
  output logic [47:0]        pkt_target_mac,
  output logic [31:0]        pkt_target_ip
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [31:0]              ip_mem  [TABLE_ENTRIES];
  logic [47:0]              mac_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_bits;

  arpc_pkg::state_t state;
  arpc_pkg::cmd_t   cur;
  logic [CNT_W-1:0] rd_cnt;
  logic             cmp_pend;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [47:0]      found_mac_r;
  logic [IDX_W-1:0] next_slot;
  logic [31:0]      rd_ip;
  logic [47:0]      rd_mac;

  logic             issue;
  logic             match;
  logic             last;
  logic             mem_we;
  logic [IDX_W-1:0] wr_idx;
  logic             load;

  assign q_pop  = (state == arpc_pkg::ST_IDLE) && q_nonempty;
  assign issue  = (state == arpc_pkg::ST_SCAN) && (rd_cnt != CNT_W'(TABLE_ENTRIES));
  assign match  = cmp_pend && valid_bits[cmp_idx] && (rd_ip == cur.key_ip);
  assign last   = cmp_pend && (cmp_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign mem_we = (state == arpc_pkg::ST_WRITE);
  assign wr_idx = found ? found_idx : next_slot;
  assign load   = (state == arpc_pkg::ST_DONE) && (!out_valid || !out_stall);

  // Cache store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ip_mem[wr_idx]  <= cur.key_ip;
      mac_mem[wr_idx] <= cur.mac;
    end
    if (issue) begin
      rd_ip  <= ip_mem[rd_cnt[IDX_W-1:0]];
      rd_mac <= mac_mem[rd_cnt[IDX_W-1:0]];
    end
  end

  // Sequencer: read one entry a cycle, compare the previous read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= arpc_pkg::ST_IDLE;
      cmp_pend   <= 1'b0;
      valid_bits <= '0;
      next_slot  <= '0;
    end else begin
      case (state)
        arpc_pkg::ST_IDLE: begin
          if (q_nonempty) begin
            rd_cnt   <= '0;
            cmp_pend <= 1'b0;
            state    <= (q_head.learn || q_head.lookup) ?
                        arpc_pkg::ST_SCAN : arpc_pkg::ST_DONE;
          end
        end
        arpc_pkg::ST_SCAN: begin
          if (match || last) begin
            cmp_pend <= 1'b0;
            state    <= cur.learn ? arpc_pkg::ST_WRITE : arpc_pkg::ST_DONE;
          end else begin
            cmp_pend <= issue;
            cmp_idx  <= rd_cnt[IDX_W-1:0];
            if (issue) begin
              rd_cnt <= rd_cnt + 1'b1;
            end
          end
        end
        arpc_pkg::ST_WRITE: begin
          valid_bits[wr_idx] <= 1'b1;
          if (!found) begin
            next_slot <= (next_slot == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : next_slot + 1'b1;
          end
          state <= cur.frame ? arpc_pkg::ST_DONE : arpc_pkg::ST_IDLE;
        end
        arpc_pkg::ST_DONE: begin
          if (load) begin
            state <= arpc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= arpc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Command and match payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if ((state == arpc_pkg::ST_SCAN) && (match || last)) begin
      found       <= match;
      found_idx   <= cmp_idx;
      found_mac_r <= match ? rd_mac : '0;
    end
  end

  // Result register: frees the back end while the result waits for transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind    <= cur.frame;
      hit            <= !cur.frame && found;
      found_mac      <= cur.frame ? '0 : found_mac_r;
      eth_dest_mac   <= cur.frame ? cur.mac : '0;
      arp_opcode_out <= cur.frame ? cur.opcode : '0;
      pkt_sender_mac <= cur.frame ? own_mac : '0;
      pkt_sender_ip  <= cur.frame ? own_ip : '0;
      pkt_target_mac <= (cur.frame && (cur.opcode == arpc_pkg::OP_REPLY)) ? cur.mac : '0;
      pkt_target_ip  <= cur.frame ? cur.tgt_ip : '0;
    end
  end

endmodule
`default_nettype wire

FILE: design/arp_cache_and_responder.sv
// ARP cache and responder: top level with configuration registers.
// A send request or a reply-only packet goes from the queue straight to the
// result register; a lookup or learn scans the cache in order, comparing each
// entry one read behind the read port.
// Input is taken while the 2-entry command queue has room; items with no work are taken and dropped.
// Reset clears all valid bits, the slot pointer and both registers.
`timescale 1ns / 1ps
`default_nettype none
module arp_cache_and_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [0:0]    cfg_index,
  input  wire logic [47:0]   cfg_data,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    func,
  input  wire logic [15:0]   rx_len,
  input  wire logic [15:0]   hw_type,
  input  wire logic [15:0]   proto_type,
  input  wire logic [15:0]   arp_opcode_in,
  input  wire logic [47:0]   sender_mac_in,
  input  wire logic [31:0]   sender_ip_in,
  input  wire logic [31:0]   query_ip,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               result_kind,
  output logic               hit,
  output logic [47:0]        found_mac,
  output logic [47:0]        eth_dest_mac,
  output logic [1:0]         arp_opcode_out,
  output logic [47:0]        pkt_sender_mac,
  output logic [31:0]        pkt_sender_ip,
  output logic [47:0]        pkt_target_mac,
  output logic [31:0]        pkt_target_ip
);

  logic [31:0]    own_ip;
  logic [47:0]    own_mac;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_nonempty;
  arpc_pkg::cmd_t front_cmd;
  arpc_pkg::cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arpc_pkg::REG_OWN_IP:  own_ip  <= cfg_data[31:0];
        arpc_pkg::REG_OWN_MAC: own_mac <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  arpc_front u_front (
    .in_valid      (in_valid),
    .func          (func),
    .rx_len        (rx_len),
    .hw_type       (hw_type),
    .proto_type    (proto_type),
    .arp_opcode_in (arp_opcode_in),
    .sender_mac_in (sender_mac_in),
    .sender_ip_in  (sender_ip_in),
    .query_ip      (query_ip),
    .own_ip        (own_ip),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (q_push),
    .cmd           (front_cmd)
  );

  arpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  arpc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .own_ip         (own_ip),
    .own_mac        (own_mac),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .hit            (hit),
    .found_mac      (found_mac),
    .eth_dest_mac   (eth_dest_mac),
    .arp_opcode_out (arp_opcode_out),
    .pkt_sender_mac (pkt_sender_mac),
    .pkt_sender_ip  (pkt_sender_ip),
    .pkt_target_mac (pkt_target_mac),
    .pkt_target_ip  (pkt_target_ip)
  );

endmodule
`default_nettype wire

FILE: design/arpc_checker.sv
// Port-level checks for the ARP cache and responder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_cache_and_responder_assert.svh"
module arpc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input wire logic         result_kind,
  input wire logic         hit,
  input wire logic [47:0]  found_mac,
  input wire logic [47:0]  eth_dest_mac,
  input wire logic [1:0]   arp_opcode_out,
  input wire logic [47:0]  pkt_sender_mac,
  input wire logic [31:0]  pkt_sender_ip,
  input wire logic [47:0]  pkt_target_mac,
  input wire logic [31:0]  pkt_target_ip
);

  `ARPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result pending after reset")

  `ARPC_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(found_mac) && $stable(eth_dest_mac) && $stable(result_kind), "stalled result changed")

  `ARPC_ASSERT(a_lookup_clean, out_valid && !result_kind |-> arp_opcode_out == 2'd0 && eth_dest_mac == '0 && pkt_sender_mac == '0 && pkt_sender_ip == '0 && pkt_target_mac == '0 && pkt_target_ip == '0, "lookup answer carries frame fields")

  `ARPC_ASSERT(a_frame_clean, out_valid && result_kind |-> !hit && found_mac == '0 && (arp_opcode_out == 2'd1 || arp_opcode_out == 2'd2), "malformed frame result")

  `ARPC_ASSERT(a_miss_zero, out_valid && !result_kind && !hit |-> found_mac == '0, "miss with nonzero MAC")

endmodule

bind arp_cache_and_responder arpc_checker u_checker (.*);
`default_nettype wire
